### hdl/bsq_pkg.sv
// shared constants, codes and types for the bounded sorted priority queue
`timescale 1ns / 1ps
`default_nettype none
package bsq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int PRIO_WIDTH  = 8;
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
    localparam int CAP_WIDTH   = 5;
    localparam int REQ_WIDTH   = 2;
    localparam int OP_WIDTH    = 3;

    localparam logic [REQ_WIDTH-1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_CLEAR   = 2'd2;

    localparam logic [OP_WIDTH-1:0] CELL_HOLD        = 3'd0;
    localparam logic [OP_WIDTH-1:0] CELL_INSERT      = 3'd1;
    localparam logic [OP_WIDTH-1:0] CELL_DROP_INSERT = 3'd2;
    localparam logic [OP_WIDTH-1:0] CELL_SHIFT       = 3'd3;
    localparam logic [OP_WIDTH-1:0] CELL_CLEAR       = 3'd4;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(DEPTH);

    typedef struct packed {
        logic [OP_WIDTH-1:0]    op;
        logic [VALUE_WIDTH-1:0] value;
        logic [PRIO_WIDTH-1:0]  prio;
    } cell_ctrl_t;

    typedef struct packed {
        logic                   valid;
        logic                   ge;
        logic [VALUE_WIDTH-1:0] value;
        logic [PRIO_WIDTH-1:0]  prio;
    } cell_data_t;

endpackage
`default_nettype wire

### hdl/bsq_cell.sv
// one slot of the sorted shift chain
`timescale 1ns / 1ps
`default_nettype none
module bsq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bsq_pkg::cell_ctrl_t ctrl,
    input  wire bsq_pkg::cell_data_t left,
    input  wire bsq_pkg::cell_data_t right,
    output bsq_pkg::cell_data_t     own
);
    import bsq_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [PRIO_WIDTH-1:0]  prio_reg;
    logic [PRIO_WIDTH-1:0]  prio_next;
    logic                   ge;

    // entry stays ahead of a new item of equal or lower priority
    assign ge = valid_reg && (prio_reg >= ctrl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                valid_next = valid_reg || left.valid || left.ge;
                if (!ge)
                begin
                    if (left.ge)
                    begin
                        value_next = ctrl.value;
                        prio_next  = ctrl.prio;
                    end
                    else
                    begin
                        value_next = left.value;
                        prio_next  = left.prio;
                    end
                end
            end
            CELL_DROP_INSERT:
            begin
                if (right.ge)
                begin
                    value_next = right.value;
                    prio_next  = right.prio;
                end
                else if (ge || !left.valid)
                begin
                    value_next = ctrl.value;
                    prio_next  = ctrl.prio;
                end
            end
            CELL_SHIFT:
            begin
                valid_next = right.valid;
                value_next = right.value;
                prio_next  = right.prio;
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign own.valid = valid_reg;
    assign own.ge    = ge;
    assign own.value = value_reg;
    assign own.prio  = prio_reg;

endmodule
`default_nettype wire

### hdl/bounded_sorted_priority_queue.sv
// top level of the bounded sorted priority queue
`timescale 1ns / 1ps
`default_nettype none
// Bounded priority queue held as a chain of slots in descending priority, equal
// priorities in arrival order. Every request (enqueue, dequeue head, clear) shifts or inserts
// across the whole chain in the same cycle, so busy stays low and a
// request may be issued on every cycle. The result of a request appears on the cycle
// after its transfer, marked by done for exactly one cycle; the receiver cannot
// stall it. An enqueue at or above capacity discards the head first and raises
// head_dropped; a dequeue on an empty queue raises underflow and changes nothing.
// A capacity of zero acts as one and values above the slot count act as the slot count.
module bounded_sorted_priority_queue (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [bsq_pkg::REQ_WIDTH-1:0]       req_type,
    input  wire logic signed [bsq_pkg::VALUE_WIDTH-1:0] item_value,
    input  wire logic [bsq_pkg::PRIO_WIDTH-1:0]      item_priority,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bsq_pkg::CAP_WIDTH-1:0]       cfg_wr_data,
    output logic                                     done,
    output logic signed [bsq_pkg::VALUE_WIDTH-1:0]   head_value,
    output logic [bsq_pkg::PRIO_WIDTH-1:0]           head_priority,
    output logic                                     is_empty,
    output logic [bsq_pkg::COUNT_WIDTH-1:0]          entry_count,
    output logic                                     underflow,
    output logic                                     head_dropped
);
    import bsq_pkg::*;

    logic [CAP_WIDTH-1:0]   capacity_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   done_reg;
    logic                   under_reg;
    logic                   under_next;
    logic                   drop_reg;
    logic                   drop_next;
    logic [COUNT_WIDTH-1:0] eff_cap;
    logic                   accept;
    cell_ctrl_t             ctrl;
    cell_data_t             cells [DEPTH];
    cell_data_t             lefts [DEPTH];
    cell_data_t             rights [DEPTH];
    logic [DEPTH-1:0]       valid_vec;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = COUNT_WIDTH'(1);
        end
        else if (32'(capacity_reg) > DEPTH)
        begin
            eff_cap = COUNT_WIDTH'(DEPTH);
        end
        else
        begin
            eff_cap = COUNT_WIDTH'(capacity_reg);
        end
    end

    always_comb
    begin
        ctrl.op    = CELL_HOLD;
        ctrl.value = item_value;
        ctrl.prio  = item_priority;
        count_next = count_reg;
        under_next = 1'b0;
        drop_next  = 1'b0;
        if (accept)
        begin
            unique case (req_type)
                REQ_ENQUEUE:
                begin
                    if (count_reg >= eff_cap)
                    begin
                        ctrl.op   = CELL_DROP_INSERT;
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.op    = CELL_INSERT;
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                end
                REQ_DEQUEUE:
                begin
                    if (count_reg == '0)
                    begin
                        under_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.op    = CELL_SHIFT;
                        count_next = count_reg - COUNT_WIDTH'(1);
                    end
                end
                REQ_CLEAR:
                begin
                    ctrl.op    = CELL_CLEAR;
                    count_next = '0;
                end
                default:
                begin
                    ctrl.op = CELL_HOLD;
                end
            endcase
        end
    end

    // neighbor wiring; the head sees a sentinel that always ranks ahead
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                lefts[i] = '{valid: 1'b0, ge: 1'b1, value: '0, prio: '0};
            end
            else
            begin
                lefts[i] = cells[i-1];
            end
            if (i == DEPTH - 1)
            begin
                rights[i] = '0;
            end
            else
            begin
                rights[i] = cells[i+1];
            end
            valid_vec[i] = cells[i].valid;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        bsq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (lefts[g]),
            .right (rights[g]),
            .own   (cells[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            under_reg    <= 1'b0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            done_reg  <= accept;
            under_reg <= under_next;
            drop_reg  <= drop_next;
        end
    end

    assign done          = done_reg;
    assign is_empty      = (count_reg == '0);
    assign head_value    = is_empty ? '0 : cells[0].value;
    assign head_priority = is_empty ? '0 : cells[0].prio;
    assign entry_count   = count_reg;
    assign underflow     = under_reg;
    assign head_dropped  = drop_reg;

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(valid_vec)) == 32'(count_reg))
        else $error("entry count disagrees with occupied slots");

    a_done_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start))
        else $error("result strobe without a request transfer");

    a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        head_dropped |-> (done && entry_count == $past(count_reg) && !underflow))
        else $error("head drop changed the entry count");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        underflow |-> (done && is_empty && $past(count_reg) == '0))
        else $error("underflow flagged on a non-empty queue");

endmodule
`default_nettype wire
